FILE: src/dfe_pkg.sv
`default_nettype none

package dfe_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_UP   = 2'd1,
    CMD_DOWN = 2'd2,
    CMD_NEXT = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    FIELD_DAY   = 2'd0,
    FIELD_MONTH = 2'd1,
    FIELD_YEAR  = 2'd2
  } field_e;

  localparam logic [4:0] DAY_MIN   = 5'd1;
  localparam logic [3:0] MONTH_MIN = 4'd1;
  localparam logic [3:0] MONTH_MAX = 4'd12;
  localparam logic [6:0] YEAR_MIN  = 7'd0;
  localparam logic [6:0] YEAR_MAX  = 7'd99;
  localparam logic [2:0] WEEK_DAYS = 3'd7;
  localparam logic [7:0] WDAY_BASE = 8'd6;
  localparam logic [7:0] LEAP_ADJ  = 8'd6;

  typedef struct packed {
    cmd_e       cmd;
    logic [4:0] load_day;
    logic [3:0] load_month;
    logic [6:0] load_year;
  } in_t;

  typedef struct packed {
    logic [4:0] out_day;
    logic [3:0] out_month;
    logic [6:0] out_year;
    logic [2:0] weekday;
    logic [1:0] out_field;
  } out_t;

  typedef struct packed {
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
    field_e     field;
  } date_t;

  localparam date_t DATE_RESET = '{
    day:   DAY_MIN,
    month: MONTH_MIN,
    year:  YEAR_MIN,
    field: FIELD_DAY
  };

  // years 2000..2099: only multiples of four are leap, 2000 included
  function automatic logic is_leap(input logic [6:0] year);
    return (year[1:0] == 2'b00);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] month_off(input logic [3:0] month);
    logic [2:0] off;
    unique case (month)
      4'd2, 4'd3, 4'd11: off = 3'd3;
      4'd4:              off = 3'd6;
      4'd5:              off = 3'd1;
      4'd6:              off = 3'd4;
      4'd7:              off = 3'd6;
      4'd8:              off = 3'd2;
      4'd9, 4'd12:       off = 3'd5;
      default:           off = 3'd0;
    endcase
    return off;
  endfunction

  // 64 and 8 are both 1 mod 7, so fold the digits down
  function automatic logic [2:0] mod7(input logic [7:0] t);
    logic [6:0] s1;
    logic [3:0] s2;
    logic [3:0] s3;
    s1 = {5'b0, t[7:6]} + {1'b0, t[5:0]};
    s2 = s1[6:3] + {1'b0, s1[2:0]};
    s3 = {3'b0, s2[3]} + {1'b0, s2[2:0]};
    return (s3 >= {1'b0, WEEK_DAYS}) ? 3'(s3 - {1'b0, WEEK_DAYS}) : s3[2:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/dfe_step.sv
`default_nettype none

module dfe_step (
  input  wire dfe_pkg::date_t state_i,
  input  wire dfe_pkg::in_t   word_i,
  output dfe_pkg::date_t      next_o
);

  logic [4:0]      dim_cur;
  logic [4:0]      dim_new;
  logic [4:0]      day_pre;
  logic [3:0]      month_new;
  logic [6:0]      year_new;
  dfe_pkg::field_e field_new;

  assign dim_cur = dfe_pkg::month_len(state_i.month, dfe_pkg::is_leap(state_i.year));

  always_comb begin
    month_new = state_i.month;
    year_new  = state_i.year;
    day_pre   = state_i.day;
    field_new = state_i.field;
    unique case (word_i.cmd)
      dfe_pkg::CMD_LOAD: begin
        if (word_i.load_month < dfe_pkg::MONTH_MIN) begin
          month_new = dfe_pkg::MONTH_MIN;
        end else if (word_i.load_month > dfe_pkg::MONTH_MAX) begin
          month_new = dfe_pkg::MONTH_MAX;
        end else begin
          month_new = word_i.load_month;
        end
        year_new  = (word_i.load_year > dfe_pkg::YEAR_MAX) ? dfe_pkg::YEAR_MAX
                                                           : word_i.load_year;
        day_pre   = (word_i.load_day < dfe_pkg::DAY_MIN) ? dfe_pkg::DAY_MIN
                                                         : word_i.load_day;
        field_new = dfe_pkg::FIELD_DAY;
      end
      dfe_pkg::CMD_UP: begin
        case (state_i.field)
          dfe_pkg::FIELD_DAY: begin
            day_pre = (state_i.day >= dim_cur) ? dfe_pkg::DAY_MIN : 5'(state_i.day + 5'd1);
          end
          dfe_pkg::FIELD_MONTH: begin
            month_new = (state_i.month >= dfe_pkg::MONTH_MAX) ? dfe_pkg::MONTH_MIN
                                                              : 4'(state_i.month + 4'd1);
          end
          default: begin
            year_new = (state_i.year >= dfe_pkg::YEAR_MAX) ? dfe_pkg::YEAR_MIN
                                                           : 7'(state_i.year + 7'd1);
          end
        endcase
      end
      dfe_pkg::CMD_DOWN: begin
        case (state_i.field)
          dfe_pkg::FIELD_DAY: begin
            day_pre = (state_i.day <= dfe_pkg::DAY_MIN) ? dim_cur : 5'(state_i.day - 5'd1);
          end
          dfe_pkg::FIELD_MONTH: begin
            month_new = (state_i.month <= dfe_pkg::MONTH_MIN) ? dfe_pkg::MONTH_MAX
                                                              : 4'(state_i.month - 4'd1);
          end
          default: begin
            year_new = (state_i.year == dfe_pkg::YEAR_MIN) ? dfe_pkg::YEAR_MAX
                                                           : 7'(state_i.year - 7'd1);
          end
        endcase
      end
      dfe_pkg::CMD_NEXT: begin
        case (state_i.field)
          dfe_pkg::FIELD_DAY:   field_new = dfe_pkg::FIELD_MONTH;
          dfe_pkg::FIELD_MONTH: field_new = dfe_pkg::FIELD_YEAR;
          default:              field_new = dfe_pkg::FIELD_DAY;
        endcase
      end
      default: begin
      end
    endcase
  end

  // clamp the day to the length of the resulting month
  assign dim_new = dfe_pkg::month_len(month_new, dfe_pkg::is_leap(year_new));

  always_comb begin
    next_o.day   = (day_pre > dim_new) ? dim_new : day_pre;
    next_o.month = month_new;
    next_o.year  = year_new;
    next_o.field = field_new;
  end

endmodule

`default_nettype wire

FILE: src/dfe_weekday.sv
`default_nettype none

module dfe_weekday (
  input  wire dfe_pkg::date_t date_i,
  output logic [2:0]          weekday_o
);

  logic       early_leap;
  logic [7:0] sum;

  assign early_leap = dfe_pkg::is_leap(date_i.year) && (date_i.month <= 4'd2);

  assign sum = dfe_pkg::WDAY_BASE
             + {1'b0, date_i.year}
             + {3'b0, date_i.year[6:2]}
             + {5'b0, dfe_pkg::month_off(date_i.month)}
             + {3'b0, date_i.day}
             + (early_leap ? dfe_pkg::LEAP_ADJ : 8'd0);

  assign weekday_o = dfe_pkg::mod7(sum);

endmodule

`default_nettype wire

FILE: src/date_field_editor_core.sv
// date field editor for a keypad-set clock, years 2000 to 2099
//
// input channel: in_valid_i / in_stall_o with in_word_i, one key command per
// word (load, up, down, next field) plus the date used by load
// output channel: out_valid_o / out_stall_i with out_word_o, one word per
// command: day, month, year, weekday (0 sunday) and the selected field
//
// a word accepted into the input register is applied to the date state and
// written to the result register at the same edge, once the result register
// is free, and then shows on out_word_o
// throughput is one word per cycle while the receiver does not stall, set by
// the combinational state update between the input and result registers
//
// reset brings the date to 1 january 2000 with the day field selected and
// empties both registers
// while the receiver stalls, the result holds and one more word can wait in
// the input register; in_stall_o rises only when both registers are full
// and out_stall_i is high

`default_nettype none

module date_field_editor_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire dfe_pkg::in_t  in_word_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output dfe_pkg::out_t      out_word_o
);

  dfe_pkg::in_t   in_q;
  logic           in_vld_q, in_vld_d;
  dfe_pkg::out_t  out_q;
  logic           out_vld_q, out_vld_d;
  dfe_pkg::date_t state_q, state_d;
  dfe_pkg::date_t state_next;
  logic [2:0]     weekday;
  logic           out_free;
  logic           move;
  logic           in_acc;

  dfe_step u_step (
    .state_i (state_q),
    .word_i  (in_q),
    .next_o  (state_next)
  );

  dfe_weekday u_weekday (
    .date_i    (state_next),
    .weekday_o (weekday)
  );

  assign out_free   = !out_vld_q || !out_stall_i;
  assign move       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign in_vld_d  = in_acc || (in_vld_q && !move);
  assign out_vld_d = move || (out_vld_q && out_stall_i);
  assign state_d   = move ? state_next : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= dfe_pkg::DATE_RESET;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      state_q   <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_word_i;
    end
    if (move) begin
      out_q.out_day   <= state_next.day;
      out_q.out_month <= state_next.month;
      out_q.out_year  <= state_next.year;
      out_q.weekday   <= weekday;
      out_q.out_field <= state_next.field;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

FILE: src/dfe_checker.sv
`default_nettype none

module dfe_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire dfe_pkg::in_t  in_word_i,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire dfe_pkg::out_t out_word_o
);

  // a stalled result word stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  // input backpressure only comes from a stalled, full output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // every result holds an in-range day, month, year, weekday and field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.out_day != 5'd0 && out_word_o.out_month != 4'd0
                 && out_word_o.out_month <= 4'd12 && out_word_o.out_year <= 7'd99
                 && out_word_o.weekday != 3'd7 && out_word_o.out_field != 2'd3)
    else $error("result word out of range");

  // an empty output fills only from a word accepted into the input register and then moved on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("output word without a matching input word");

  logic unused_in;
  assign unused_in = ^in_word_i;

endmodule

bind date_field_editor_core dfe_checker u_dfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire
